// ===== rtl/packbits_frame_unpacker_assert.svh =====
// Assertion macros shared by the packbits frame unpacker checker.
`ifndef PACKBITS_FRAME_UNPACKER_ASSERT_SVH
`define PACKBITS_FRAME_UNPACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define PBFU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define PBFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pbfu_pkg.sv =====
// Shared types and constants of the packbits frame unpacker.
package pbfu_pkg;

	localparam int unsigned FrameSize = 64000;
	localparam int unsigned PosW      = 16;
	localparam int unsigned BaseW     = 20;
	localparam int unsigned AddrW     = 21;

	localparam logic [PosW-1:0] FRAME_SIZE = PosW'(FrameSize);

	// Control byte that does nothing.
	localparam logic [7:0] CTRL_NOP = 8'h80;

	// Configuration register indexes.
	localparam logic CFG_TRANSPARENT_ZERO = 1'b0;
	localparam logic CFG_FRAME_BASE       = 1'b1;

	typedef enum logic [3:0] {
		PH_CONTROL = 4'b0001,
		PH_RUNVAL  = 4'b0010,
		PH_LITERAL = 4'b0100,
		PH_DISCARD = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t          phase;
		logic [7:0]      literals_left;
		logic [7:0]      run_count;
		logic [PosW-1:0] pixel_position;
	} dec_state_t;

	typedef struct packed {
		logic [AddrW-1:0] write_address;
		logic [7:0]       run_length;
		logic [7:0]       pixel_value;
		logic             write_enable;
		logic             frame_done;
		logic             overrun;
	} cmd_t;

endpackage

// ===== rtl/packbits_frame_unpacker.sv =====
// Top level of the packbits frame unpacker: stream ports, registers and output stage.
//
// PackBits frame unpacker. One compressed byte enters per item on the s_axis side.
// A control byte 0x81..0xFF starts a run whose value byte leaves as one fill
// command of 2..128 pixels; a control byte 0x00..0x7F starts 1..128 literal bytes,
// each of which leaves as a one-pixel command; 0x80 does nothing. Control bytes
// produce no item on the m_axis side. Commands carry the buffer address
// (frame_base plus pixel position), length and value; tlast marks the command that
// completes the 64000-pixel frame, after which the position restarts at zero. A run
// or literal block that passes the frame end is clipped and flagged as overrun;
// the rest of such a literal block is swallowed. With transparent_zero set, zero
// pixels leave with write_enable low so the buffer keeps its old contents. The
// block sustains one item per cycle unless m_axis stalls: a byte is captured in an
// input register and then decoded straight into the output register, which drives
// m_axis. The output register lets a new byte in while a finished command waits,
// and the decode state loop (phase, counters, pixel position) is one register. The
// user must write configuration via cfg_we/cfg_index/cfg_data only while the block
// is idle, which the block does not enforce; it applies to later bytes.
module packbits_frame_unpacker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [20:0] write_address, [28:21] run_length,
	                                    // [36:29] pixel_value, [39:37] zero
	output logic [1:0]  m_axis_tuser,   // [0] write_enable, [1] overrun
	output logic        m_axis_tlast    // frame_done
);

	logic                          transparent_zero_q;
	logic [pbfu_pkg::BaseW-1:0]    frame_base_q;

	logic                          valid_s1;
	logic [7:0]                    byte_s1;

	pbfu_pkg::dec_state_t          state_q;
	pbfu_pkg::dec_state_t          state_nxt;
	logic                          has_result;
	pbfu_pkg::cmd_t                cmd;

	logic                          out_valid_q;
	pbfu_pkg::cmd_t                out_cmd_q;

	logic                          advance;

	// Decode the captured byte whenever the output register is free or draining.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_zero_q <= 1'b0;
			frame_base_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbfu_pkg::CFG_TRANSPARENT_ZERO: transparent_zero_q <= cfg_data[0];
				pbfu_pkg::CFG_FRAME_BASE:       frame_base_q       <= cfg_data;
				default:                        frame_base_q       <= frame_base_q;
			endcase
		end
	end

	// Input register: hold while the decode stage is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	pbfu_step u_step (
		.cur              (state_q),
		.source_byte      (byte_s1),
		.transparent_zero (transparent_zero_q),
		.frame_base       (frame_base_q),
		.nxt              (state_nxt),
		.has_result       (has_result),
		.cmd              (cmd)
	);

	// Decoder state: advance once per decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= pbfu_pkg::PH_CONTROL;
			state_q.literals_left  <= '0;
			state_q.run_count      <= '0;
			state_q.pixel_position <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register: load a command, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_cmd_q <= cmd;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_cmd_q.pixel_value, out_cmd_q.run_length,
		out_cmd_q.write_address};
	assign m_axis_tuser  = {out_cmd_q.overrun, out_cmd_q.write_enable};
	assign m_axis_tlast  = out_cmd_q.frame_done;

endmodule

// ===== rtl/pbfu_step.sv =====
// Decode step: next decoder state and the fill command for one source byte.
module pbfu_step (
	input  pbfu_pkg::dec_state_t            cur,
	input  logic [7:0]                      source_byte,
	input  logic                            transparent_zero,
	input  logic [pbfu_pkg::BaseW-1:0]      frame_base,
	output pbfu_pkg::dec_state_t            nxt,
	output logic                            has_result,
	output pbfu_pkg::cmd_t                  cmd
);

	logic [7:0]                  want;
	logic [7:0]                  len;
	logic [7:0]                  lit;
	logic [7:0]                  lit_dec;
	logic [pbfu_pkg::PosW-1:0]   pos;
	logic [pbfu_pkg::PosW-1:0]   rem;
	logic                        done;
	logic [7:0]                  len_c;

	assign lit     = (cur.literals_left == 8'd0) ? 8'd1 : cur.literals_left;
	assign lit_dec = lit - 8'd1;

	// Pick the request size for this byte.
	always_comb begin
		want       = 8'd0;
		len        = 8'd0;
		has_result = 1'b0;
		unique case (cur.phase)
			pbfu_pkg::PH_RUNVAL: begin
				want       = cur.run_count;
				len        = cur.run_count;
				has_result = 1'b1;
			end
			pbfu_pkg::PH_LITERAL: begin
				want       = lit;
				len        = 8'd1;
				has_result = 1'b1;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	// Clip against the frame end.
	assign pos   = cur.pixel_position;
	assign rem   = (pos < pbfu_pkg::FRAME_SIZE) ? (pbfu_pkg::FRAME_SIZE - pos)
		: pbfu_pkg::PosW'(1);
	assign done  = {8'd0, len} >= rem;
	assign len_c = done ? rem[7:0] : len;

	assign cmd.write_address = {1'b0, frame_base} + pbfu_pkg::AddrW'(pos);
	assign cmd.run_length    = len_c;
	assign cmd.pixel_value   = source_byte;
	assign cmd.write_enable  = !(transparent_zero && (source_byte == 8'd0));
	assign cmd.frame_done    = done;
	assign cmd.overrun       = {8'd0, want} > rem;

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			pbfu_pkg::PH_RUNVAL: begin
				nxt.phase = pbfu_pkg::PH_CONTROL;
			end
			pbfu_pkg::PH_LITERAL: begin
				nxt.literals_left = lit_dec;
				if (lit_dec == 8'd0) begin
					nxt.phase = pbfu_pkg::PH_CONTROL;
				end else if (done) begin
					nxt.phase = pbfu_pkg::PH_DISCARD;
				end else begin
					nxt.phase = pbfu_pkg::PH_LITERAL;
				end
			end
			pbfu_pkg::PH_DISCARD: begin
				nxt.literals_left = cur.literals_left - 8'd1;
				if (cur.literals_left == 8'd1) begin
					nxt.phase = pbfu_pkg::PH_CONTROL;
				end
			end
			default: begin
				if (source_byte == pbfu_pkg::CTRL_NOP) begin
					nxt.phase = pbfu_pkg::PH_CONTROL;
				end else if (source_byte[7]) begin
					nxt.run_count = 8'(9'd257 - {1'b0, source_byte});
					nxt.phase     = pbfu_pkg::PH_RUNVAL;
				end else begin
					nxt.literals_left = source_byte + 8'd1;
					nxt.phase         = pbfu_pkg::PH_LITERAL;
				end
			end
		endcase
		if (has_result) begin
			nxt.pixel_position = done ? '0 : (pos + pbfu_pkg::PosW'(len_c));
		end
	end

endmodule

// ===== rtl/pbfu_checker.sv =====
// Port-level checker of the packbits frame unpacker and its bind.
`include "packbits_frame_unpacker_assert.svh"

module pbfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled command holds its payload.
	`PBFU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled command changed")

	// Every command covers 1..128 pixels.
	`PBFU_ASSERT_NOW(a_len_range, m_axis_tvalid, m_axis_tdata[28:21] != 8'd0 && m_axis_tdata[28:21] <= 8'd128, "run length out of range")

	// A clipped run always ends the frame; single literals of an overlong block flag early.
	`PBFU_ASSERT_NOW(a_overrun_done, m_axis_tvalid && m_axis_tuser[1] && m_axis_tdata[28:21] != 8'd1, m_axis_tlast, "overrun without frame end")

	// Only zero pixels skip the write.
	`PBFU_ASSERT_NOW(a_skip_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[36:29] == 8'd0, "skip on nonzero pixel")

endmodule

bind packbits_frame_unpacker pbfu_checker u_pbfu_checker (.*);

// ===== test/packbits_frame_unpacker_tb.sv =====
// Self-checking testbench of the packbits frame unpacker: directed and random streams.
`timescale 1ns / 1ps

module packbits_frame_unpacker_tb;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_PHASES  = 8;
	localparam int unsigned PHASE_ITEMS    = 100;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = pbfu_pkg::CFG_TRANSPARENT_ZERO;
	logic [19:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_tdata = '0;      // [7:0] source_byte
	logic        m_axis_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_axis_tdata;      // [20:0] write_address, [28:21] run_length,
	                                // [36:29] pixel_value, [39:37] zero
	logic [1:0]  m_axis_tuser;      // [0] write_enable, [1] overrun
	logic        m_axis_tlast;      // frame_done

	packbits_frame_unpacker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Decoder mirror: configuration and decode state as the block should hold them.
	logic                      tz_mode   = 1'b0;
	logic [19:0]               base_addr = '0;
	pbfu_pkg::phase_t          dec_phase = pbfu_pkg::PH_CONTROL;
	logic [7:0]                lits_left = '0;
	logic [7:0]                run_cnt   = '0;
	logic [pbfu_pkg::PosW-1:0] pix_pos   = '0;

	pbfu_pkg::cmd_t pending_cmds[$];   // fill commands still to come out of the block
	int unsigned mismatch_count = 0;
	int unsigned counted_bytes  = 0;
	int unsigned idle_cycles    = 0;
	bit          steady = 1'b0;     // both sides run without gaps while set

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Build one fill command at the current pixel position; clip it at the frame end.
	function automatic pbfu_pkg::cmd_t fill_cmd(input int unsigned want,
	                                            input int unsigned len,
	                                            input logic [7:0] value);
		pbfu_pkg::cmd_t c;
		int unsigned    pos;
		int unsigned    rem;
		int unsigned    n;
		pos = pix_pos;
		n = len;
		rem = (pos < pbfu_pkg::FrameSize) ? pbfu_pkg::FrameSize - pos : 1;
		c.frame_done = (n >= rem);
		if (c.frame_done)
			n = rem;
		c.overrun = (want > rem);
		c.write_address = pbfu_pkg::AddrW'(base_addr + pos);
		c.run_length = n[7:0];
		c.pixel_value = value;
		c.write_enable = !(tz_mode && value == 8'h00);
		pix_pos = c.frame_done ? '0 : pbfu_pkg::PosW'(pos + n);
		return c;
	endfunction

	// Advance the mirror by one source byte; return 1 when the byte yields a command.
	function automatic bit decode_byte(input logic [7:0] b, output pbfu_pkg::cmd_t c);
		bit has_cmd;
		has_cmd = 1'b0;
		c = '0;
		case (dec_phase)
			pbfu_pkg::PH_RUNVAL: begin
				c = fill_cmd(run_cnt, run_cnt, b);
				dec_phase = pbfu_pkg::PH_CONTROL;
				has_cmd = 1'b1;
			end
			pbfu_pkg::PH_LITERAL: begin
				if (lits_left == 8'd0)
					lits_left = 8'd1;
				c = fill_cmd(lits_left, 1, b);
				lits_left = lits_left - 8'd1;
				if (lits_left == 8'd0)
					dec_phase = pbfu_pkg::PH_CONTROL;
				else
					dec_phase = c.frame_done ? pbfu_pkg::PH_DISCARD : pbfu_pkg::PH_LITERAL;
				has_cmd = 1'b1;
			end
			pbfu_pkg::PH_DISCARD: begin
				// swallow the tail of a literal block that ran past the frame end
				lits_left = lits_left - 8'd1;
				if (lits_left == 8'd0)
					dec_phase = pbfu_pkg::PH_CONTROL;
			end
			default: begin
				if (b == pbfu_pkg::CTRL_NOP) begin
					dec_phase = pbfu_pkg::PH_CONTROL;
				end else if (b[7]) begin
					run_cnt = 8'(9'd257 - {1'b0, b});
					dec_phase = pbfu_pkg::PH_RUNVAL;
				end else begin
					lits_left = b + 8'd1;
					dec_phase = pbfu_pkg::PH_LITERAL;
				end
			end
		endcase
		return has_cmd;
	endfunction

	// Pixel value with a bias toward zero so transparency gets exercised.
	function automatic logic [7:0] pick_value();
		return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
	endfunction

	// Offer one byte after a random gap, hold it until accepted, then predict.
	task automatic send_byte(input logic [7:0] b);
		int unsigned    gap;
		pbfu_pkg::cmd_t c;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (!(dec_phase == pbfu_pkg::PH_DISCARD ||
		      (dec_phase == pbfu_pkg::PH_CONTROL && b == pbfu_pkg::CTRL_NOP)))
			counted_bytes++;
		if (decode_byte(b, c))
			pending_cmds.push_back(c);
	endtask

	task automatic send_run(input int unsigned len, input logic [7:0] value);
		send_byte(8'(257 - len));
		send_byte(value);
	endtask

	task automatic send_literals(input int unsigned n);
		send_byte(8'(n - 1));
		repeat (n) send_byte(pick_value());
	endtask

	// Drop valid, drain every expected command, then let the pipeline settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; the block takes it at the next edge.
	task automatic write_reg(input logic idx, input logic [19:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == pbfu_pkg::CFG_TRANSPARENT_ZERO)
			tz_mode = data[0];
		else
			base_addr = data;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic tz, input logic [19:0] base);
		wait_idle();
		write_reg(pbfu_pkg::CFG_TRANSPARENT_ZERO, {19'd0, tz});
		write_reg(pbfu_pkg::CFG_FRAME_BASE, base);
	endtask

	// Fill with runs (and a single literal where needed) until exactly `target` pixels remain in the frame (target >= 1).
	task automatic advance_to(input int unsigned target);
		int unsigned rem;
		int unsigned d;
		while (dec_phase != pbfu_pkg::PH_CONTROL) send_byte(8'($urandom_range(0, 255)));
		rem = pbfu_pkg::FrameSize - pix_pos;
		while (rem > target) begin
			d = rem - target;
			if (d == 1)
				send_literals(1);
			else if (d == 129)
				send_run(127, 8'($urandom_range(0, 255)));
			else
				send_run((d > 128) ? 128 : d, 8'($urandom_range(0, 255)));
			rem = pbfu_pkg::FrameSize - pix_pos;
		end
	endtask

	// Every control class, including the no-op and literals that look like controls.
	task automatic test_control_codes();
		set_config(1'b0, 20'h00000);
		send_byte(8'h00); send_byte(8'h00);                  // one literal zero
		send_byte(8'h01); send_byte(8'hFF); send_byte(8'h55);
		send_byte(pbfu_pkg::CTRL_NOP);
		send_byte(8'h81); send_byte(8'hAA);                  // longest run
		send_byte(8'hFF); send_byte(8'h00);                  // shortest run
		send_byte(8'hFE); send_byte(8'h7F);
		send_byte(pbfu_pkg::CTRL_NOP); send_byte(pbfu_pkg::CTRL_NOP);
		send_byte(8'h02); send_byte(8'h01); send_byte(pbfu_pkg::CTRL_NOP); send_byte(8'hFE);
	endtask

	// Zero pixels skip with transparency on and write with it off; top base address.
	task automatic test_transparency();
		set_config(1'b1, 20'hFFFFF);
		send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'h00);
		send_byte(8'h81); send_byte(8'h00);
		send_byte(8'h01); send_byte(8'h00); send_byte(8'h01);
		send_byte(8'h83); send_byte(8'h5A);
		set_config(1'b0, 20'h00000);
		send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hFD); send_byte(8'h00);
	endtask

	// Exact frame completion, clipped runs and literal blocks that overshoot.
	task automatic test_frame_end();
		set_config(1'($urandom_range(0, 1)), 20'($urandom_range(0, 20'hFFFFF)));
		advance_to(40);
		send_run(40, 8'h3C);                 // lands exactly on the frame end
		advance_to(10);
		send_run(128, 8'hC3);                // clipped to ten pixels
		advance_to(3);
		send_literals(128);                  // three land, the rest are swallowed
		send_literals(128);                  // a full literal block mid-frame
		advance_to(1);
		send_literals(1);                    // single literal completes the frame
		advance_to(2);
		send_literals(1);
		send_run(2, 8'h00);                  // one pixel short of the run
	endtask

	// Mostly well-formed runs and literal blocks, with no-ops and raw noise mixed in.
	task automatic test_random_stream();
		int unsigned phase_end;
		int unsigned kind;
		int unsigned n;
		logic [19:0] base;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: base = 20'h00000;
				1: base = 20'hFFFFF;
				default: base = 20'($urandom_range(0, 20'hFFFFF));
			endcase
			set_config((p < 2) ? 1'(p) : 1'($urandom_range(0, 1)), base);
			// push some phases near the frame end so random content crosses it
			if (p == 2 || p == 5)
				advance_to($urandom_range(1, 400));
			phase_end = counted_bytes + PHASE_ITEMS;
			while (counted_bytes < phase_end) begin
				if ($urandom_range(0, 15) == 0)
					steady = !steady;
				kind = $urandom_range(0, 99);
				if (kind < 45) begin
					send_run($urandom_range(2, 128), pick_value());
				end else if (kind < 85) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128)
					                               : $urandom_range(1, 8);
					send_literals(n);
				end else if (kind < 90) begin
					send_byte(pbfu_pkg::CTRL_NOP);
				end else begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
				end
			end
			steady = 1'b0;
		end
	endtask

	// Result side: stall at random, take each command and compare it with the oldest one due.
	initial begin : result_checker
		int unsigned    stall;
		pbfu_pkg::cmd_t got;
		pbfu_pkg::cmd_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.write_address = m_axis_tdata[20:0];
			got.run_length    = m_axis_tdata[28:21];
			got.pixel_value   = m_axis_tdata[36:29];
			got.write_enable  = m_axis_tuser[0];
			got.overrun       = m_axis_tuser[1];
			got.frame_done    = m_axis_tlast;
			if (pending_cmds.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected command: addr=%h len=%0d val=%h we=%b done=%b ovr=%b",
					         got.write_address, got.run_length, got.pixel_value,
					         got.write_enable, got.frame_done, got.overrun);
				mismatch_count++;
			end else begin
				want = pending_cmds.pop_front();
				if (got.write_address !== want.write_address ||
				    got.run_length !== want.run_length ||
				    got.pixel_value !== want.pixel_value ||
				    got.write_enable !== want.write_enable ||
				    got.frame_done !== want.frame_done ||
				    got.overrun !== want.overrun) begin
					if (mismatch_count < 10)
						$display("command mismatch: expected addr=%h len=%0d val=%h we=%b done=%b ovr=%b, got addr=%h len=%0d val=%h we=%b done=%b ovr=%b",
						         want.write_address, want.run_length, want.pixel_value,
						         want.write_enable, want.frame_done, want.overrun,
						         got.write_address, got.run_length, got.pixel_value,
						         got.write_enable, got.frame_done, got.overrun);
					mismatch_count++;
				end
			end
		end
	end

	// Stop a hung run: count cycles in which neither side moves an item.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_control_codes();
		test_transparency();
		test_frame_end();
		test_random_stream();
		wait_idle();
		repeat (8) @(posedge clk);
		if (pending_cmds.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
